/* rtl/core/cmsc_pkg.sv */
// cmsc_pkg: shared types and constants for the collatz memo step counter
// no dependencies; imported by cmsc_memo and collatz_memo_step_counter
`default_nettype none

package cmsc_pkg;

  // field widths
  localparam int unsigned START_W = 32;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned TRAJ_W  = 64;

  // default memo table depth
  localparam int unsigned DEF_TABLE_DEPTH = 65536;

  // saturation value of the step count
  localparam logic [LEN_W-1:0] SAT_MAX = '1;

  // largest value whose 3x+1 still fits in the trajectory width
  localparam logic [TRAJ_W-1:0] ODD_LIMIT = 64'h5555_5555_5555_5554;

  // trailing zeros dropped per cycle at most
  localparam int unsigned CHUNK_W = 8;

  // walk sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOOKUP,
    ST_DONE
  } walk_state_t;

endpackage : cmsc_pkg

`default_nettype wire

/* rtl/core/collatz_memo_step_counter.sv */
// collatz_memo_step_counter: Collatz total stopping time with a memo table
// depends on cmsc_pkg and cmsc_memo
// walk: each step does an odd move or drops up to 8 trailing zeros of an even move;
//   a lookup follows each move that ends inside the table; then the result is registered
// throughput: one start value at a time; the walk loop sets the rate
// reset: the memo table is zeroed by a sweep over every entry, no input taken meanwhile
`default_nettype none

module collatz_memo_step_counter
  import cmsc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [START_W-1:0] in_start_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [LEN_W-1:0]   out_path_length,
  output logic                    out_overflowed
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [TRAJ_W-1:0]  DEPTH_X = TRAJ_W'(TABLE_DEPTH);
  localparam logic [START_W:0]   DEPTH_S = (START_W + 1)'(TABLE_DEPTH);
  localparam logic [TRAJ_W-1:0]  ONE_X   = TRAJ_W'(1);

  // trailing zeros of a narrow chunk; CHUNK_W when all zero
  function automatic logic [3:0] tz_chunk(input logic [CHUNK_W-1:0] v);
    logic [3:0] n;
    n = 4'(CHUNK_W);
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = 4'(i);
      end
    end
    return n;
  endfunction

  walk_state_t        state_r, state_nxt;
  logic [TRAJ_W-1:0]  x_r, x_nxt;
  logic [LEN_W-1:0]   steps_r, steps_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic               bad_r, bad_nxt;

  logic               out_valid_r;
  logic [LEN_W-1:0]   out_len_r;
  logic               out_ovf_r;
  logic               out_load;

  logic               mem_ready;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic [LEN_W-1:0]   mem_rd_data;
  logic               mem_wr_en;

  logic [TRAJ_W-1:0]  x_mv;
  logic [4:0]         mv_add;
  logic               mv_done;
  logic               mv_bad;
  logic [LEN_W:0]     mv_sum;
  logic [LEN_W-1:0]   mv_steps;
  logic [3:0]         tz;
  logic [LEN_W:0]     hit_sum;

  // one move of the walk: odd 3x+1, or a chunk of trailing zeros
  always_comb begin
    tz      = tz_chunk(x_r[CHUNK_W-1:0]);
    x_mv    = x_r;
    mv_add  = '0;
    mv_done = 1'b0;
    mv_bad  = 1'b0;
    if (x_r[0]) begin
      if (x_r > ODD_LIMIT) begin
        mv_bad = 1'b1;
      end else begin
        x_mv    = (x_r << 1) + x_r + ONE_X;
        mv_add  = 5'd1;
        mv_done = 1'b1;
      end
    end else if (tz == 4'(CHUNK_W)) begin
      // the even move ends here when the next bit up is set
      x_mv    = x_r >> CHUNK_W;
      mv_add  = 5'(CHUNK_W);
      mv_done = x_r[CHUNK_W];
    end else begin
      x_mv    = x_r >> tz[2:0];
      mv_add  = 5'(tz);
      mv_done = 1'b1;
    end
    mv_sum   = {1'b0, steps_r} + (LEN_W + 1)'(mv_add);
    mv_steps = mv_sum[LEN_W] ? SAT_MAX : mv_sum[LEN_W-1:0];
    hit_sum  = {1'b0, steps_r} + {1'b0, mem_rd_data};
  end

  // walk sequencer: next state and memo control
  always_comb begin
    state_nxt   = state_r;
    x_nxt       = x_r;
    steps_nxt   = steps_r;
    start_nxt   = start_r;
    bad_nxt     = bad_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = x_mv[AW-1:0];
    mem_wr_en   = 1'b0;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = mem_ready;
        if (in_valid && mem_ready) begin
          start_nxt = in_start_value;
          x_nxt     = TRAJ_W'(in_start_value);
          steps_nxt = '0;
          bad_nxt   = (in_start_value == '0);
          if (in_start_value == '0 || in_start_value == START_W'(1)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (mv_bad) begin
          bad_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          x_nxt     = x_mv;
          steps_nxt = mv_steps;
          if (mv_done) begin
            if (mv_steps == SAT_MAX) begin
              state_nxt = ST_DONE;
            end else if (x_mv < DEPTH_X) begin
              mem_rd_en = 1'b1;
              state_nxt = ST_LOOKUP;
            end
          end
        end
      end
      ST_LOOKUP: begin
        if (mem_rd_data != '0) begin
          steps_nxt = hit_sum[LEN_W] ? SAT_MAX : hit_sum[LEN_W-1:0];
          state_nxt = ST_DONE;
        end else if (x_r == ONE_X) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          mem_wr_en = !bad_r && ({1'b0, start_r} < DEPTH_S);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // walk datapath registers
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    steps_r <= steps_nxt;
    start_r <= start_nxt;
    bad_r   <= bad_nxt;
  end

  // result register, decouples the walk from the output transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_len_r <= bad_r ? '0 : steps_r;
      out_ovf_r <= bad_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_path_length = out_len_r;
  assign out_overflowed  = out_ovf_r;

  // memo table
  cmsc_memo #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_memo (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .rd_data  (mem_rd_data),
    .wr_en    (mem_wr_en),
    .wr_addr  (start_r[AW-1:0]),
    .wr_data  (steps_r),
    .clr_done (mem_ready)
  );

  // an overflowed result never carries a length
  a_ovf_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovf_r |-> out_len_r == '0)
    else $error("overflowed result with nonzero length");

  // the trajectory never reaches zero while walking
  a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> x_r != '0)
    else $error("zero trajectory value in walk");

  // a lookup only happens for values inside the table
  a_lookup_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOKUP |-> x_r < DEPTH_X)
    else $error("lookup outside memo table");

  // an accepted transaction always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("accepted start value not processed");

endmodule : collatz_memo_step_counter

`default_nettype wire

/* rtl/core/cmsc_memo.sv */
// cmsc_memo: memo table of path lengths with a zero sweep after reset
// depends on cmsc_pkg; one write port, one registered read port
`default_nettype none

module cmsc_memo
  import cmsc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [LEN_W-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [LEN_W-1:0] wr_data,
  output logic                  clr_done
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  logic [LEN_W-1:0] mem [TABLE_DEPTH];
  logic [LEN_W-1:0] rd_data_r;
  logic [AW-1:0]    clr_addr_r;
  logic             clr_busy_r;

  // zero sweep over every entry after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // write port, shared by the sweep and the result write-back
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_done = !clr_busy_r;

endmodule : cmsc_memo

`default_nettype wire
